[src/sgr_pkg.sv]
// Shared types, constants and code tables for the SGR attribute delta encoder.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package sgr_pkg;

    // Number slots: 8 flag-off codes, 8 flag-on codes, 5 fg fields, 5 bg fields
    localparam int SLOT_W    = 5;
    localparam int NUM_SLOTS = 26;
    localparam int OFF_BASE  = 0;
    localparam int ON_BASE   = 8;
    localparam int FG_BASE   = 16;
    localparam int BG_BASE   = 21;
    localparam int COL_SLOTS = 5;

    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [SLOT_W:0]      slot_ext_t;
    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    // Colour modes
    localparam logic [1:0] MODE_DEFAULT = 2'd0;
    localparam logic [1:0] MODE_BASIC   = 2'd1;
    localparam logic [1:0] MODE_PALETTE = 2'd2;
    localparam logic [1:0] MODE_RGB     = 2'd3;

    // ASCII bytes
    localparam logic [7:0] CHAR_ESC  = 8'h1B;
    localparam logic [7:0] CHAR_LBR  = 8'h5B;  // '['
    localparam logic [7:0] CHAR_SEP  = 8'h3B;  // ';'
    localparam logic [7:0] CHAR_END  = 8'h6D;  // 'm'
    localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'

    // Colour code numbers
    localparam logic [7:0] CODE_FG_DEFAULT = 8'd39;
    localparam logic [7:0] CODE_BG_DEFAULT = 8'd49;
    localparam logic [7:0] CODE_FG_EXT     = 8'd38;
    localparam logic [7:0] CODE_BG_EXT     = 8'd48;
    localparam logic [7:0] CODE_PALETTE    = 8'd5;
    localparam logic [7:0] CODE_RGB        = 8'd2;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ERR,
        ST_ESC,
        ST_LBR,
        ST_HUND,
        ST_TENS,
        ST_ONES,
        ST_SEP,
        ST_END
    } state_t;

    // Output byte source
    typedef enum logic [2:0] {
        SEL_ESC,
        SEL_LBR,
        SEL_SEP,
        SEL_HUND,
        SEL_TENS,
        SEL_ONES,
        SEL_END,
        SEL_ERR
    } byte_sel_t;

    // Controller -> datapath
    typedef struct packed {
        logic      load;
        logic      emit;
        byte_sel_t sel;
        logic      last;
        slot_t     slot;
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic       out_free;
        logic       differ;
        logic       room;
        slot_mask_t mask;
        logic       ge100;
        logic       ge10;
    } dp_stat_t;

    // SGR code that sets a style flag
    function automatic logic [7:0] flag_on_code(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'd1;
            3'd1: c = 8'd2;
            3'd2: c = 8'd3;
            3'd3: c = 8'd4;
            3'd4: c = 8'd5;
            3'd5: c = 8'd7;
            3'd6: c = 8'd9;
            3'd7: c = 8'd0;
        endcase
        return c;
    endfunction

    // SGR code that clears a style flag (bold and faint share one)
    function automatic logic [7:0] flag_off_code(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'd22;
            3'd1: c = 8'd22;
            3'd2: c = 8'd23;
            3'd3: c = 8'd24;
            3'd4: c = 8'd25;
            3'd5: c = 8'd27;
            3'd6: c = 8'd29;
            3'd7: c = 8'd0;
        endcase
        return c;
    endfunction

    // Which colour fields a mode writes
    function automatic logic [COL_SLOTS-1:0] colour_mask(input logic [1:0] mode);
        logic [COL_SLOTS-1:0] m;
        unique case (mode)
            MODE_DEFAULT: m = 5'b00001;
            MODE_BASIC:   m = 5'b00001;
            MODE_PALETTE: m = 5'b00111;
            MODE_RGB:     m = 5'b11111;
        endcase
        return m;
    endfunction

    // Number written in colour field k
    function automatic logic [7:0] colour_field(input logic        is_bg,
                                                input logic [1:0]  mode,
                                                input logic [23:0] val,
                                                input logic [2:0]  k);
        logic [7:0] v;
        logic [7:0] ext;
        ext = is_bg ? CODE_BG_EXT : CODE_FG_EXT;
        unique case (mode)
            MODE_DEFAULT: v = is_bg ? CODE_BG_DEFAULT : CODE_FG_DEFAULT;
            MODE_BASIC:   v = val[7:0];
            MODE_PALETTE: begin
                if (k == 3'd0)      v = ext;
                else if (k == 3'd1) v = CODE_PALETTE;
                else                v = val[7:0];
            end
            MODE_RGB: begin
                if (k == 3'd0)      v = ext;
                else if (k == 3'd1) v = CODE_RGB;
                else if (k == 3'd2) v = val[23:16];
                else if (k == 3'd3) v = val[15:8];
                else                v = val[7:0];
            end
        endcase
        return v;
    endfunction

endpackage

[src/sgr_attribute_delta_encoder.sv]
// Top level of the SGR attribute delta encoder: controller plus datapath.
// Depends on sgr_pkg, sgr_ctrl and sgr_datapath.
`timescale 1ns / 1ps

// Takes a wanted and a previous text attribute set per input beat and emits
// the SGR escape sequence that changes one into the other, one byte per
// output beat, with m_last on the final byte. Equal sets produce no output;
// differing sets with s_room_ok low produce one beat with m_status set. The
// block works on one item at a time: it captures an item, classifies it, then
// emits one output byte per cycle while m_ready stays high. The single output
// byte register sets the pace; the last byte can wait there while the next
// item is accepted.
module sgr_attribute_delta_encoder import sgr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [23:0] s_want_fg,
    input  logic [1:0]  s_want_fg_mode,
    input  logic [23:0] s_want_bg,
    input  logic [1:0]  s_want_bg_mode,
    input  logic [7:0]  s_want_flags,
    input  logic [23:0] s_prev_fg,
    input  logic [1:0]  s_prev_fg_mode,
    input  logic [23:0] s_prev_bg,
    input  logic [1:0]  s_prev_bg_mode,
    input  logic [7:0]  s_prev_flags,
    input  logic        s_room_ok,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_status,
    output logic        m_last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sgr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sgr_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_want_fg      (s_want_fg),
        .s_want_fg_mode (s_want_fg_mode),
        .s_want_bg      (s_want_bg),
        .s_want_bg_mode (s_want_bg_mode),
        .s_want_flags   (s_want_flags),
        .s_prev_fg      (s_prev_fg),
        .s_prev_fg_mode (s_prev_fg_mode),
        .s_prev_bg      (s_prev_bg),
        .s_prev_bg_mode (s_prev_bg_mode),
        .s_prev_flags   (s_prev_flags),
        .s_room_ok      (s_room_ok),
        .cmd            (cmd),
        .stat           (stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_status       (m_status),
        .m_last         (m_last)
    );

endmodule

[src/sgr_ctrl.sv]
// Sequencer of the SGR encoder: walks ESC '[', the present number slots with
// their digits and separators, and the closing 'm', or a single error beat. Depends on sgr_pkg.
`timescale 1ns / 1ps

module sgr_ctrl import sgr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t    state_reg, state_next;
    slot_t     slot_reg, slot_next;
    slot_ext_t first_idx;
    slot_ext_t after_idx;

    // Lowest present slot at or above lo; NUM_SLOTS when none
    function automatic slot_ext_t first_from(input slot_mask_t mask, input slot_ext_t lo);
        slot_ext_t r;
        r = slot_ext_t'(NUM_SLOTS);
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (mask[i] && slot_ext_t'(i) >= lo) r = slot_ext_t'(i);
        end
        return r;
    endfunction

    assign first_idx = first_from(stat.mask, '0);
    assign after_idx = first_from(stat.mask, slot_ext_t'(slot_reg) + slot_ext_t'(1));

    // State and slot pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.sel    = SEL_ESC;
        cmd.last   = 1'b0;
        cmd.slot   = slot_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!stat.differ)    state_next = ST_IDLE;
                else if (!stat.room) state_next = ST_ERR;
                else                 state_next = ST_ESC;
            end
            ST_ERR: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_ERR;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ESC: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_ESC;
                    state_next = ST_LBR;
                end
            end
            ST_LBR: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_LBR;
                    slot_next  = first_idx[SLOT_W-1:0];
                    state_next = ST_HUND;
                end
            end
            // leading digit of the current number
            ST_HUND: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.ge100) begin
                        cmd.sel    = SEL_HUND;
                        state_next = ST_TENS;
                    end else if (stat.ge10) begin
                        cmd.sel    = SEL_TENS;
                        state_next = ST_ONES;
                    end else begin
                        cmd.sel = SEL_ONES;
                        if (after_idx == slot_ext_t'(NUM_SLOTS)) begin
                            state_next = ST_END;
                        end else begin
                            slot_next  = after_idx[SLOT_W-1:0];
                            state_next = ST_SEP;
                        end
                    end
                end
            end
            ST_TENS: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_TENS;
                    state_next = ST_ONES;
                end
            end
            ST_ONES: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_ONES;
                    if (after_idx == slot_ext_t'(NUM_SLOTS)) begin
                        state_next = ST_END;
                    end else begin
                        slot_next  = after_idx[SLOT_W-1:0];
                        state_next = ST_SEP;
                    end
                end
            end
            ST_SEP: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_SEP;
                    state_next = ST_HUND;
                end
            end
            ST_END: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_END;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[src/sgr_datapath.sv]
// Datapath of the SGR encoder: captured attribute deltas, slot value select,
// decimal digit split and the output beat register. Depends on sgr_pkg.
`timescale 1ns / 1ps

module sgr_datapath import sgr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [23:0] s_want_fg,
    input  logic [1:0]  s_want_fg_mode,
    input  logic [23:0] s_want_bg,
    input  logic [1:0]  s_want_bg_mode,
    input  logic [7:0]  s_want_flags,
    input  logic [23:0] s_prev_fg,
    input  logic [1:0]  s_prev_fg_mode,
    input  logic [23:0] s_prev_bg,
    input  logic [1:0]  s_prev_bg_mode,
    input  logic [7:0]  s_prev_flags,
    input  logic        s_room_ok,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_status,
    output logic        m_last
);

    // Captured item
    logic [7:0]  off_reg, on_reg;
    logic        fg_ch_reg, bg_ch_reg, room_reg;
    logic [1:0]  fg_mode_reg, bg_mode_reg;
    logic [23:0] fg_val_reg, bg_val_reg;

    // Output beat
    logic        m_valid_reg;
    logic [7:0]  byte_reg;
    logic        status_reg, last_reg;
    logic [7:0]  byte_next;

    // Slot value and digits
    slot_t       fg_k, bg_k;
    logic [7:0]  slot_val;
    logic [7:0]  hund_sub, rem8;
    logic [1:0]  hund;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [7:0]  ones8;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            off_reg     <= s_prev_flags & ~s_want_flags;
            on_reg      <= s_want_flags & ~s_prev_flags;
            fg_ch_reg   <= (s_want_fg != s_prev_fg) || (s_want_fg_mode != s_prev_fg_mode);
            bg_ch_reg   <= (s_want_bg != s_prev_bg) || (s_want_bg_mode != s_prev_bg_mode);
            room_reg    <= s_room_ok;
            fg_mode_reg <= s_want_fg_mode;
            fg_val_reg  <= s_want_fg;
            bg_mode_reg <= s_want_bg_mode;
            bg_val_reg  <= s_want_bg;
        end
    end

    // Present slots
    assign stat.mask[ON_BASE-1:OFF_BASE]  = off_reg;
    assign stat.mask[FG_BASE-1:ON_BASE]   = on_reg;
    assign stat.mask[BG_BASE-1:FG_BASE]   = fg_ch_reg ? colour_mask(fg_mode_reg) : '0;
    assign stat.mask[NUM_SLOTS-1:BG_BASE] = bg_ch_reg ? colour_mask(bg_mode_reg) : '0;
    assign stat.differ   = (|off_reg) || (|on_reg) || fg_ch_reg || bg_ch_reg;
    assign stat.room     = room_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

    // Number held in the addressed slot
    assign fg_k = cmd.slot - slot_t'(FG_BASE);
    assign bg_k = cmd.slot - slot_t'(BG_BASE);

    always_comb begin
        if (cmd.slot < slot_t'(ON_BASE))
            slot_val = flag_off_code(cmd.slot[2:0]);
        else if (cmd.slot < slot_t'(FG_BASE))
            slot_val = flag_on_code(cmd.slot[2:0]);
        else if (cmd.slot < slot_t'(BG_BASE))
            slot_val = colour_field(1'b0, fg_mode_reg, fg_val_reg, fg_k[2:0]);
        else
            slot_val = colour_field(1'b1, bg_mode_reg, bg_val_reg, bg_k[2:0]);
    end

    // Decimal split: hundreds by compare, tens by reciprocal of 10
    always_comb begin
        if (slot_val >= 8'd200) begin
            hund     = 2'd2;
            hund_sub = 8'd200;
        end else if (slot_val >= 8'd100) begin
            hund     = 2'd1;
            hund_sub = 8'd100;
        end else begin
            hund     = 2'd0;
            hund_sub = 8'd0;
        end
        rem8      = slot_val - hund_sub;
        tens_prod = 15'(rem8[6:0]) * 15'd205;
        tens      = tens_prod[14:11];
        ones8     = rem8 - {1'b0, tens, 3'b000} - {3'b000, tens, 1'b0};
    end

    assign stat.ge100 = slot_val >= 8'd100;
    assign stat.ge10  = slot_val >= 8'd10;

    // Byte for the requested source
    always_comb begin
        unique case (cmd.sel)
            SEL_ESC:  byte_next = CHAR_ESC;
            SEL_LBR:  byte_next = CHAR_LBR;
            SEL_SEP:  byte_next = CHAR_SEP;
            SEL_HUND: byte_next = CHAR_ZERO | {6'b0, hund};
            SEL_TENS: byte_next = CHAR_ZERO | {4'b0, tens};
            SEL_ONES: byte_next = CHAR_ZERO | {4'b0, ones8[3:0]};
            SEL_END:  byte_next = CHAR_END;
            SEL_ERR:  byte_next = 8'h00;
            default:  byte_next = 8'h00;
        endcase
    end

    // Output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            byte_reg   <= byte_next;
            status_reg <= (cmd.sel == SEL_ERR);
            last_reg   <= cmd.last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = byte_reg;
    assign m_status   = status_reg;
    assign m_last     = last_reg;

endmodule

[test/tb_sgr_attribute_delta_encoder.sv]
// Testbench for sgr_attribute_delta_encoder: directed and random attribute pairs,
// a bursty sender, a stalling receiver and a scoreboard with its own SGR predictor.
// Depends on sgr_pkg and the RTL top level sgr_attribute_delta_encoder.
`timescale 1ns / 1ps

module tb_sgr_attribute_delta_encoder;
    import sgr_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 4;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 180;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 20;

    // SGR numbers for flag bits 0..7, bit 0 in the low byte
    localparam logic [63:0] FLAG_SET_NUMS =
        {8'd0, 8'd9, 8'd7, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1};
    localparam logic [63:0] FLAG_CLEAR_NUMS =
        {8'd0, 8'd29, 8'd27, 8'd25, 8'd24, 8'd23, 8'd22, 8'd22};

    typedef struct {
        logic [23:0] want_fg;
        logic [1:0]  want_fg_mode;
        logic [23:0] want_bg;
        logic [1:0]  want_bg_mode;
        logic [7:0]  want_flags;
        logic [23:0] prev_fg;
        logic [1:0]  prev_fg_mode;
        logic [23:0] prev_bg;
        logic [1:0]  prev_bg_mode;
        logic [7:0]  prev_flags;
        logic        room_ok;
    } attr_pair_t;

    typedef struct {
        logic [7:0] out_byte;
        logic       status;
        logic       last;
    } sgr_beat_t;

    typedef enum {
        RX_STEADY,
        RX_SPARSE_STALLS,
        RX_EVERY_THIRD,
        RX_MOSTLY_STALLED
    } rx_style_t;

    // Predicts the escape sequence of each accepted pair and checks output beats
    class sgr_scoreboard;
        sgr_beat_t   pending_beats[$];
        logic [7:0]  codes[$];
        logic [7:0]  text[$];
        int unsigned items_noted;
        int unsigned errors;

        task report(string what, logic [7:0] want_v, logic [7:0] got_v);
            $display("ERROR at %0t: %s: expected 0x%02h, got 0x%02h",
                     $time, what, want_v, got_v);
            errors++;
        endtask

        // Plain decimal, no leading zeros
        function void push_decimal(logic [7:0] v);
            if (v >= 8'd100)
                text.push_back(CHAR_ZERO + v / 8'd100);
            if (v >= 8'd10)
                text.push_back(CHAR_ZERO + (v / 8'd10) % 8'd10);
            text.push_back(CHAR_ZERO + v % 8'd10);
        endfunction

        // SGR numbers that select one colour
        function void add_colour(logic is_bg, logic [1:0] mode, logic [23:0] val);
            logic [7:0] ext;
            ext = is_bg ? CODE_BG_EXT : CODE_FG_EXT;
            case (mode)
                MODE_DEFAULT: codes.push_back(is_bg ? CODE_BG_DEFAULT : CODE_FG_DEFAULT);
                MODE_BASIC:   codes.push_back(val[7:0]);
                MODE_PALETTE: begin
                    codes.push_back(ext);
                    codes.push_back(CODE_PALETTE);
                    codes.push_back(val[7:0]);
                end
                default: begin
                    codes.push_back(ext);
                    codes.push_back(CODE_RGB);
                    codes.push_back(val[23:16]);
                    codes.push_back(val[15:8]);
                    codes.push_back(val[7:0]);
                end
            endcase
        endfunction

        function void note_item(attr_pair_t a);
            logic      fg_changed;
            logic      bg_changed;
            logic [7:0] cleared;
            logic [7:0] raised;
            sgr_beat_t b;
            items_noted++;
            fg_changed = (a.want_fg != a.prev_fg) || (a.want_fg_mode != a.prev_fg_mode);
            bg_changed = (a.want_bg != a.prev_bg) || (a.want_bg_mode != a.prev_bg_mode);
            // Nothing to do for equal sets, room or not
            if (!fg_changed && !bg_changed && a.want_flags == a.prev_flags)
                return;
            // No room: a single error beat
            if (!a.room_ok) begin
                b.out_byte = 8'h00;
                b.status   = 1'b1;
                b.last     = 1'b1;
                pending_beats.push_back(b);
                return;
            end
            codes.delete();
            text.delete();
            cleared = a.prev_flags & ~a.want_flags;
            raised  = a.want_flags & ~a.prev_flags;
            for (int i = 0; i < 8; i++)
                if (cleared[i])
                    codes.push_back(FLAG_CLEAR_NUMS[i*8 +: 8]);
            for (int i = 0; i < 8; i++)
                if (raised[i])
                    codes.push_back(FLAG_SET_NUMS[i*8 +: 8]);
            if (fg_changed)
                add_colour(1'b0, a.want_fg_mode, a.want_fg);
            if (bg_changed)
                add_colour(1'b1, a.want_bg_mode, a.want_bg);
            // ESC '[' numbers joined by ';' then 'm'
            text.push_back(CHAR_ESC);
            text.push_back(CHAR_LBR);
            foreach (codes[k]) begin
                if (k != 0)
                    text.push_back(CHAR_SEP);
                push_decimal(codes[k]);
            end
            if (codes.size() == 0)
                text.push_back(CHAR_ZERO);
            text.push_back(CHAR_END);
            foreach (text[k]) begin
                b.out_byte = text[k];
                b.status   = 1'b0;
                b.last     = (k == text.size() - 1);
                pending_beats.push_back(b);
            end
        endfunction

        task check_result(logic [7:0] out_byte, logic status, logic last);
            sgr_beat_t e;
            if (pending_beats.size() == 0) begin
                report("output beat with nothing pending", 8'h00, out_byte);
                return;
            end
            e = pending_beats.pop_front();
            if (out_byte !== e.out_byte)
                report("m_out_byte", e.out_byte, out_byte);
            if (status !== e.status)
                report("m_status", {7'd0, e.status}, {7'd0, status});
            if (last !== e.last)
                report("m_last", {7'd0, e.last}, {7'd0, last});
        endtask
    endclass

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [23:0] s_want_fg      = '0;
    logic [1:0]  s_want_fg_mode = '0;
    logic [23:0] s_want_bg      = '0;
    logic [1:0]  s_want_bg_mode = '0;
    logic [7:0]  s_want_flags   = '0;
    logic [23:0] s_prev_fg      = '0;
    logic [1:0]  s_prev_fg_mode = '0;
    logic [23:0] s_prev_bg      = '0;
    logic [1:0]  s_prev_bg_mode = '0;
    logic [7:0]  s_prev_flags   = '0;
    logic        s_room_ok      = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_status;
    logic        m_last;

    sgr_scoreboard scoreboard = new();

    int        burst_left  = 0;
    int        idle_cycles = 0;
    int        style_left  = 0;
    int        hold_left   = 0;
    int        third_count = 0;
    bit        hold_started = 1'b0;
    bit        ready_next;
    rx_style_t rx_style = RX_STEADY;

    sgr_attribute_delta_encoder dut (.*);

    always #CLK_HALF aclk = ~aclk;

    // One beat per call; between bursts the sender idles for a random gap
    task automatic send_pair(attr_pair_t a);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_want_fg      <= a.want_fg;
        s_want_fg_mode <= a.want_fg_mode;
        s_want_bg      <= a.want_bg;
        s_want_bg_mode <= a.want_bg_mode;
        s_want_flags   <= a.want_flags;
        s_prev_fg      <= a.prev_fg;
        s_prev_fg_mode <= a.prev_fg_mode;
        s_prev_bg      <= a.prev_bg;
        s_prev_bg_mode <= a.prev_bg_mode;
        s_prev_flags   <= a.prev_flags;
        s_room_ok      <= a.room_ok;
        do @(posedge aclk); while (!s_ready);
        scoreboard.note_item(a);
    endtask

    function automatic attr_pair_t mk_pair(
        logic [23:0] wfg, logic [1:0] wfm, logic [23:0] wbg, logic [1:0] wbm,
        logic [7:0] wfl, logic [23:0] pfg, logic [1:0] pfm, logic [23:0] pbg,
        logic [1:0] pbm, logic [7:0] pfl, logic room);
        attr_pair_t a;
        a.want_fg = wfg;  a.want_fg_mode = wfm;
        a.want_bg = wbg;  a.want_bg_mode = wbm;
        a.want_flags = wfl;
        a.prev_fg = pfg;  a.prev_fg_mode = pfm;
        a.prev_bg = pbg;  a.prev_bg_mode = pbm;
        a.prev_flags = pfl;
        a.room_ok = room;
        return a;
    endfunction

    // Bytes spread over one-, two- and three-digit values and the extremes
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 9));
            1:       return 8'($urandom_range(10, 99));
            2:       return 8'($urandom_range(100, 255));
            default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    function automatic logic [23:0] rand_colour();
        if ($urandom_range(0, 2) == 0)
            return 24'($urandom_range(0, 24'hFFFFFF));
        return {rand_byte(), rand_byte(), rand_byte()};
    endfunction

    // Mostly a previous set close to the wanted one, some fully independent
    function automatic attr_pair_t rand_pair();
        attr_pair_t a;
        a.want_fg      = rand_colour();
        a.want_fg_mode = 2'($urandom_range(0, 3));
        a.want_bg      = rand_colour();
        a.want_bg_mode = 2'($urandom_range(0, 3));
        a.want_flags   = 8'($urandom_range(0, 255));
        a.prev_fg      = a.want_fg;
        a.prev_fg_mode = a.want_fg_mode;
        a.prev_bg      = a.want_bg;
        a.prev_bg_mode = a.want_bg_mode;
        a.prev_flags   = a.want_flags;
        if ($urandom_range(0, 99) < 15) begin
            a.prev_fg      = rand_colour();
            a.prev_fg_mode = 2'($urandom_range(0, 3));
            a.prev_bg      = rand_colour();
            a.prev_bg_mode = 2'($urandom_range(0, 3));
            a.prev_flags   = 8'($urandom_range(0, 255));
        end else begin
            if ($urandom_range(0, 1))
                a.prev_flags = a.want_flags ^ 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1)) begin
                a.prev_fg      = rand_colour();
                a.prev_fg_mode = 2'($urandom_range(0, 3));
            end
            if ($urandom_range(0, 1)) begin
                a.prev_bg      = rand_colour();
                a.prev_bg_mode = 2'($urandom_range(0, 3));
            end
        end
        a.room_ok = ($urandom_range(0, 9) != 0);
        return a;
    endfunction

    // Receiver: check beats, stall in styles that are picked anew at random intervals,
    // and hold off once for a long stretch so the block backs up
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            scoreboard.check_result(m_out_byte, m_status, m_last);
        if (style_left == 0) begin
            rx_style   = rx_style_t'($urandom_range(0, 3));
            style_left = $urandom_range(16, 96);
        end
        style_left--;
        third_count = (third_count + 1) % 3;
        if (!hold_started && scoreboard.items_noted >= HOLD_AFTER) begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else begin
            case (rx_style)
                RX_STEADY:        ready_next = 1'b1;
                RX_SPARSE_STALLS: ready_next = ($urandom_range(0, 3) != 0);
                RX_EVERY_THIRD:   ready_next = (third_count != 0);
                default:          ready_next = ($urandom_range(0, 3) == 0);
            endcase
        end
        m_ready <= ready_next;
    end

    // Watchdog: too long without a beat on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Equal sets, with and without room
        send_pair(mk_pair(24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00, 1'b1));
        send_pair(mk_pair(24'hFFFFFF, MODE_RGB, 24'h123456, MODE_PALETTE, 8'hFF,
                          24'hFFFFFF, MODE_RGB, 24'h123456, MODE_PALETTE, 8'hFF, 1'b0));
        // No room
        send_pair(mk_pair(24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h01,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00, 1'b0));
        // Every flag set, every flag cleared
        send_pair(mk_pair(24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'hFF,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00, 1'b1));
        send_pair(mk_pair(24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'hFF, 1'b1));
        // Bold and faint cleared share an off code; italic stays on
        send_pair(mk_pair(24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h04,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h07, 1'b1));
        // Unassigned top flag bit set, then cleared along with bold set
        send_pair(mk_pair(24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h80,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00, 1'b1));
        send_pair(mk_pair(24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h01,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h80, 1'b1));
        // Default mode: a value change alone still counts, and so does a change from basic mode
        send_pair(mk_pair(24'hFFFFFF, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00, 1'b1));
        send_pair(mk_pair(24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_BASIC, 8'h00, 1'b1));
        // Basic codes across digit counts, upper value bits ignored
        send_pair(mk_pair(24'hFFFF00, MODE_BASIC, 24'd0, MODE_DEFAULT, 8'h00,
                          24'd0, MODE_BASIC, 24'd0, MODE_DEFAULT, 8'h00, 1'b1));
        send_pair(mk_pair(24'h000009, MODE_BASIC, 24'd0, MODE_DEFAULT, 8'h00,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00, 1'b1));
        send_pair(mk_pair(24'h00000A, MODE_BASIC, 24'h000063, MODE_BASIC, 8'h00,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00, 1'b1));
        send_pair(mk_pair(24'h123464, MODE_BASIC, 24'hABCDFF, MODE_BASIC, 8'h00,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00, 1'b1));
        // Palette and RGB extremes
        send_pair(mk_pair(24'h0000FF, MODE_PALETTE, 24'hFFFF00, MODE_PALETTE, 8'h00,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00, 1'b1));
        send_pair(mk_pair(24'hFFFFFF, MODE_RGB, 24'h000000, MODE_RGB, 8'h00,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00, 1'b1));
        send_pair(mk_pair(24'h640A09, MODE_RGB, 24'h090A64, MODE_RGB, 8'h00,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00, 1'b1));
        // Mode change alone, same value
        send_pair(mk_pair(24'h000005, MODE_RGB, 24'd0, MODE_DEFAULT, 8'h00,
                          24'h000005, MODE_PALETTE, 24'd0, MODE_DEFAULT, 8'h00, 1'b1));
        // Longest sequence with all flags cleared, then all set; both colours three-digit RGB
        send_pair(mk_pair(24'hC8C8C8, MODE_RGB, 24'hFFFFFF, MODE_RGB, 8'h00,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'hFF, 1'b1));
        send_pair(mk_pair(24'hFFFFFF, MODE_RGB, 24'hC8C8C8, MODE_RGB, 8'hFF,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00, 1'b1));
        // Everything differs but no room
        send_pair(mk_pair(24'hFFFFFF, MODE_RGB, 24'hFFFFFF, MODE_RGB, 8'hFF,
                          24'd0, MODE_DEFAULT, 24'd0, MODE_DEFAULT, 8'h00, 1'b0));

        // Random pairs
        repeat (RANDOM_ITEMS)
            send_pair(rand_pair());
        s_valid <= 1'b0;

        while (scoreboard.pending_beats.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (scoreboard.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sgr_attribute_delta_encoder.f]
src/sgr_pkg.sv
src/sgr_ctrl.sv
src/sgr_datapath.sv
src/sgr_attribute_delta_encoder.sv
test/tb_sgr_attribute_delta_encoder.sv
